// File: design/rks_pkg.sv
// shared types and sizes for the record key sorter
// holds the record layout, cell operation codes and controller states
// no dependencies
package rks_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_BITS  = 17;
  localparam int TAG_BITS  = 16;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int DATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } record_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

// File: design/rks_cell.sv
// one cell of the sorting chain: holds a single record
// inserts in key order against the broadcast record, or shifts towards the output
// depends on rks_pkg
module rks_cell import rks_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cell_op_t op,
  input  record_t  in_rec,
  input  record_t  left_rec,
  input  logic     left_gt,
  input  record_t  right_rec,
  output record_t  rec,
  output logic     gt
);

  record_t rec_next;

  // empty cells count as larger than anything, equal keys stay put (stable order)
  assign gt = !rec.valid || (rec.key > in_rec.key);

  always_comb begin
    rec_next = rec;
    unique case (op)
      OP_INSERT: begin
        if (gt) begin
          if (left_gt) begin
            rec_next = left_rec;
          end else begin
            rec_next = in_rec;
          end
        end
      end
      OP_SHIFT: begin
        rec_next = right_rec;
      end
      OP_HOLD: begin
        rec_next = rec;
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

  // only the valid bit needs a reset, key and tag are ignored while it is low
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else begin
      rec.valid <= rec_next.valid;
    end
    rec.key <= rec_next.key;
    rec.tag <= rec_next.tag;
  end

endmodule

// File: design/rks_ctrl.sv
// run controller: counts kept records, tracks drops and paces the emit phase
// drives the operation code shared by every cell of the chain
// depends on rks_pkg
module rks_ctrl import rks_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tlast,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output logic     m_tlast,
  output logic     overflow,
  output cell_op_t op
);

  state_t              state, state_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] remain, remain_next;
  logic                dropped, dropped_next;
  logic                room;

  assign room     = count < CNT_BITS'(DEPTH);
  assign overflow = dropped;
  assign m_tlast  = remain == CNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      remain  <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      remain  <= remain_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    remain_next  = remain;
    dropped_next = dropped;
    op           = OP_HOLD;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (room) begin
            op         = OP_INSERT;
            count_next = count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          if (s_tlast) begin
            state_next  = ST_EMIT;
            remain_next = count_next;
            count_next  = '0;
          end
        end
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          op          = OP_SHIFT;
          remain_next = remain - 1'b1;
          if (m_tlast) begin
            state_next   = ST_LOAD;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// File: design/record_key_sorter_unit.sv
// record key sorter: stable ascending sort over a chain of DEPTH insertion cells
// load: one record a cycle, each placed in key order on the cycle it is accepted
// emit: first result the cycle after the last record, then one result a cycle
// while m_tready is high; the controller paces both phases
// synchronous reset empties the chain and returns to loading with no drop pending
// depends on rks_pkg, rks_cell and rks_ctrl
module record_key_sorter_unit import rks_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_BITS-1:0] s_tdata,  // key, tag, zero fill
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_BITS-1:0] m_tdata,  // key_res, tag_res, zero fill
  output logic                 m_tlast,
  output logic                 m_tuser   // overflow
);

  cell_op_t op;
  record_t  in_rec;
  record_t  cell_rec [DEPTH];
  logic     cell_gt  [DEPTH];

  assign in_rec.valid = 1'b1;
  assign in_rec.key   = s_tdata[KEY_BITS-1:0];
  assign in_rec.tag   = s_tdata[KEY_BITS +: TAG_BITS];

  rks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .overflow (m_tuser),
    .op       (op)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    record_t left_rec;
    logic    left_gt;
    record_t right_rec;

    if (i == 0) begin : g_head
      assign left_rec = in_rec;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    rks_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .in_rec    (in_rec),
      .left_rec  (left_rec),
      .left_gt   (left_gt),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .gt        (cell_gt[i])
    );
  end

  assign m_tdata = DATA_BITS'({cell_rec[0].tag, cell_rec[0].key});

endmodule

// File: design/rks_checker.sv
// port-level checks for the record key sorter
// bound to record_key_sorter_unit; depends on rks_pkg
module rks_checker import rks_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [DATA_BITS-1:0] m_tdata,
  input logic                 m_tlast,
  input logic                 m_tuser
);

  // never loading and emitting at once
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input accepted while results pending");

  // closing transaction starts the emit phase straight away
  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("no result after last record");

  // after the final result the block takes records again
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("not back to loading after final result");

  // overflow flag constant across one run of results
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tuser == $past(m_tuser))))
    else $error("overflow flag changed within a run");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind record_key_sorter_unit rks_checker u_rks_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: test/tb_record_key_sorter_unit.sv
// testbench for record_key_sorter_unit: streams runs of keyed records and checks the sorted output
// a class keeps its own stable sort of each run and matches every result field by field
// depends on rks_pkg and record_key_sorter_unit
module tb_record_key_sorter_unit import rks_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } held_rec_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic                is_last;
    logic                ovf;
  } sorted_rec_t;

  class record_sort_board;
    held_rec_t   run_recs[DEPTH];
    int          run_len;
    bit          run_dropped;
    sorted_rec_t sorted_due[$];
    int          errors;

    function new();
      run_len     = 0;
      run_dropped = 0;
      errors      = 0;
    endfunction

    // accepted input record; closes and sorts the run on last
    function void take_record(logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag, logic lst);
      held_rec_t   cur;
      sorted_rec_t res;
      int          i;
      int          j;
      if (run_len < DEPTH) begin
        run_recs[run_len] = '{key: key, tag: tag};
        run_len++;
      end else begin
        run_dropped = 1;
      end
      if (!lst) return;
      // insertion sort with strict compare keeps equal keys in arrival order
      for (i = 1; i < run_len; i++) begin
        cur = run_recs[i];
        j = i;
        while (j > 0 && run_recs[j-1].key > cur.key) begin
          run_recs[j] = run_recs[j-1];
          j--;
        end
        run_recs[j] = cur;
      end
      for (i = 0; i < run_len; i++) begin
        res.key     = run_recs[i].key;
        res.tag     = run_recs[i].tag;
        res.is_last = (i == run_len - 1);
        res.ovf     = run_dropped;
        sorted_due.push_back(res);
      end
      run_len     = 0;
      run_dropped = 0;
    endfunction

    function void check_sorted(logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag,
                               logic lst, logic ovf);
      sorted_rec_t exp_rec;
      if (sorted_due.size() == 0) begin
        $error("result with nothing pending: key_res %0d tag_res %0d", key, tag);
        errors++;
        return;
      end
      exp_rec = sorted_due.pop_front();
      if (key !== exp_rec.key) begin
        $error("key_res: expected %0d, got %0d", exp_rec.key, key);
        errors++;
      end
      if (tag !== exp_rec.tag) begin
        $error("tag_res: expected %0d, got %0d", exp_rec.tag, tag);
        errors++;
      end
      if (lst !== exp_rec.is_last) begin
        $error("final_res: expected %0d, got %0d", exp_rec.is_last, lst);
        errors++;
      end
      if (ovf !== exp_rec.ovf) begin
        $error("overflow: expected %0d, got %0d", exp_rec.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [DATA_BITS-1:0] s_tdata;  // key, tag, zero fill
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [DATA_BITS-1:0] m_tdata;  // key_res, tag_res, zero fill
  logic                 m_tlast;
  logic                 m_tuser;  // overflow

  record_sort_board board = new();
  int               send_burst = 0;

  record_key_sorter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_record(input logic [KEY_BITS-1:0] key, input logic [TAG_BITS-1:0] tag,
                             input logic lst);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(8, 30);
    end
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(DATA_BITS-KEY_BITS-TAG_BITS){1'b0}}, tag, key};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    board.take_record(key, tag, lst);
  endtask

  task automatic send_run(input int n);
    int                  mode;
    int                  i;
    logic [KEY_BITS-1:0] key;
    mode = $urandom_range(0, 2);
    for (i = 0; i < n; i++) begin
      case (mode)
        0: begin
          // few distinct keys so ties are common
          key = KEY_BITS'($urandom_range(0, 3));
        end
        1: begin
          key = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
        end
        default: begin
          key = $urandom_range(0, 1) ? KEY_BITS'($urandom_range(0, 7))
                                     : KEY_BITS'((1 << KEY_BITS) - 1 - $urandom_range(0, 7));
        end
      endcase
      send_record(key, TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1)), i == n - 1);
    end
  endtask

  // receiver: random stall per result, bursts of full rate, one long hold-off
  initial begin
    int stall;
    int got;
    int burst;
    got      = 0;
    burst    = 0;
    m_tready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (got == 20) begin
        stall = 400;
      end else if (burst > 0) begin
        stall = 0;
        burst--;
      end else begin
        stall = $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 30);
      end
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_sorted(m_tdata[KEY_BITS-1:0], m_tdata[KEY_BITS +: TAG_BITS], m_tlast, m_tuser);
      got++;
    end
  end

  initial begin
    #1000000;
    $display("tb_record_key_sorter_unit failed");
    $finish;
  end

  initial begin
    int total;
    int n;
    int r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single records at both extremes
    send_record('1, '1, 1'b1);
    send_record('0, '0, 1'b1);
    // equal keys must come out in arrival order
    send_record(KEY_BITS'(777), TAG_BITS'(1), 1'b0);
    send_record(KEY_BITS'(777), TAG_BITS'(2), 1'b0);
    send_record(KEY_BITS'(777), TAG_BITS'(3), 1'b0);
    send_record(KEY_BITS'(777), TAG_BITS'(4), 1'b0);
    send_record(KEY_BITS'(777), TAG_BITS'(5), 1'b1);
    // reversed order with a tie in the middle
    send_record('1, 16'h0011, 1'b0);
    send_record(KEY_BITS'(65536), 16'h0022, 1'b0);
    send_record(KEY_BITS'(4096), 16'h0033, 1'b0);
    send_record(KEY_BITS'(4096), 16'h0044, 1'b0);
    send_record(KEY_BITS'(1), 16'h0055, 1'b0);
    send_record('0, 16'h0066, 1'b1);
    // already in order
    send_record('0, 16'haaaa, 1'b0);
    send_record('1, 16'h5555, 1'b1);

    // random runs; one overruns the store including its last record, one fills it exactly
    total = 0;
    r     = 0;
    while (total < 200) begin
      if (r == 1) n = DEPTH + 2;
      else if (r == 4) n = DEPTH;
      else n = $urandom_range(1, 12);
      send_run(n);
      total += n;
      r++;
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (board.sorted_due.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 16) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_record_key_sorter_unit passed");
    end else begin
      $display("tb_record_key_sorter_unit failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/rks_pkg.sv
design/rks_cell.sv
design/rks_ctrl.sv
design/record_key_sorter_unit.sv
design/rks_checker.sv
test/tb_record_key_sorter_unit.sv
